// ----- sv/osdte_pkg.sv -----
// Shared types and constants for the OSD text refresh encoder.
// No dependencies; imported by osd_text_refresh_encoder_unit.
`default_nettype none

package osdte_pkg;

  // Command word kinds, as carried on the output tuser
  typedef enum logic [1:0] {
    KindRepeat  = 2'd0,
    KindWrite8  = 2'd1,
    KindWrite16 = 2'd2
  } kind_e;

  // Configuration register indexes
  localparam logic [1:0] RegColorAttr  = 2'd0;
  localparam logic [1:0] RegFirstColor = 2'd1;
  localparam logic [1:0] RegOtherColor = 2'd2;

  // Register reset values
  localparam logic       ColorAttrRst  = 1'b1;
  localparam logic [2:0] FirstColorRst = 3'd4;
  localparam logic [2:0] OtherColorRst = 3'd1;

  // Locate word sent ahead of the first cell of a frame
  localparam logic [15:0] LocateWord = 16'h0000;

  // Row-start word: 0x1000 base, 0x800 attribute, colour in bits 10:8
  function automatic logic [15:0] row_start_word(input logic       attr,
                                                 input logic [2:0] color,
                                                 input logic [6:0] code);
    row_start_word = {4'b0001, attr, color, 1'b0, code};
  endfunction

endpackage

`default_nettype wire

// ----- sv/osd_text_refresh_encoder_unit.sv -----
// OSD text refresh encoder: character codes in raster order to command words.
// Depends on osdte_pkg (kinds, register indexes, row-start word format).
// A cell's first command word is registered, valid in the next cycle.
// Throughput: one cell per cycle while the output is ready; a frame's first
// cell stalls the input: its locate and row-start words share one register.
// Reset (rst_ni, asynchronous, active low) clears the cell counters, the
// previous code and the output valid flags, and loads register reset values.
`default_nettype none

module osd_text_refresh_encoder_unit #(
  parameter int COLUMNS = 28,
  parameter int ROWS    = 11
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [2:0]  cfg_wdata_i,
  // Character input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [6:0] char_code, [7] zero
  // Command word output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] command_word
  output logic [1:0]       m_axis_tuser,   // [1:0] word_kind
  output logic             m_axis_tlast    // last command of the cell
);

  import osdte_pkg::*;

  localparam int ColW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ColW-1:0] ColLast = ColW'(COLUMNS - 1);
  localparam logic [RowW-1:0] RowLast = RowW'(ROWS - 1);

  // Configuration registers
  logic       attr_q;
  logic [2:0] first_color_q;
  logic [2:0] other_color_q;

  // Cell position and left neighbour
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [6:0]      prev_code_q;

  // Output register and the pending row-start word behind it
  logic        out_valid_q;
  logic [15:0] out_word_q;
  kind_e       out_kind_q;
  logic        out_last_q;
  logic        pend_valid_q;
  logic [15:0] pend_word_q;

  logic        in_xfer;
  logic        out_xfer;
  logic [6:0]  code;
  logic [2:0]  row_color;
  logic [15:0] res_word;
  kind_e       res_kind;
  logic        frame_start;

  assign code     = s_axis_tdata[6:0];
  assign out_xfer = out_valid_q && m_axis_tready;
  assign s_axis_tready = !pend_valid_q && (!out_valid_q || m_axis_tready);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q        <= ColorAttrRst;
      first_color_q <= FirstColorRst;
      other_color_q <= OtherColorRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegColorAttr:  attr_q        <= cfg_wdata_i[0];
        RegFirstColor: first_color_q <= cfg_wdata_i;
        RegOtherColor: other_color_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Encode the current cell
  always_comb begin
    row_color   = (row_q == '0) ? first_color_q : other_color_q;
    frame_start = (col_q == '0) && (row_q == '0);
    if (col_q == '0) begin
      res_word = row_start_word(attr_q, row_color, code);
      res_kind = KindWrite16;
    end else if (code != prev_code_q) begin
      res_word = {9'd0, code};
      res_kind = KindWrite8;
    end else begin
      res_word = 16'd0;
      res_kind = KindRepeat;
    end
  end

  // Raster position advance with wrap
  always_comb begin
    col_d = col_q + 1'b1;
    row_d = row_q;
    if (col_q == ColLast) begin
      col_d = '0;
      row_d = (row_q == RowLast) ? '0 : row_q + 1'b1;
    end
  end

  // Position and neighbour state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      prev_code_q <= '0;
    end else if (in_xfer) begin
      col_q       <= col_d;
      row_q       <= row_d;
      prev_code_q <= code;
    end
  end

  // Output stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= frame_start;
      end else if (out_xfer) begin
        out_valid_q  <= pend_valid_q;
        pend_valid_q <= 1'b0;
      end
    end
  end

  // Output stage payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pend_word_q <= res_word;
      if (frame_start) begin
        out_word_q <= LocateWord;
        out_kind_q <= KindWrite16;
        out_last_q <= 1'b0;
      end else begin
        out_word_q <= res_word;
        out_kind_q <= res_kind;
        out_last_q <= 1'b1;
      end
    end else if (out_xfer && pend_valid_q) begin
      out_word_q <= pend_word_q;
      out_kind_q <= KindWrite16;
      out_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // A pending row-start word always sits behind a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("pending word without output word");

  // First cell of a frame leaves its row-start word pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && col_q == '0 && row_q == '0) |=> pend_valid_q)
    else $error("frame start lost its row-start word");

  // Only the locate word is a non-final command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (out_kind_q == KindWrite16 && out_word_q == LocateWord))
    else $error("unexpected non-final command");

  // Repeats carry a zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KindRepeat) |-> (out_word_q == 16'd0))
    else $error("repeat with non-zero word");

endmodule

`default_nettype wire
